>>> rtl/nbl_pkg.sv
// Shared types, character codes and reset values for the N-Triples byte lexer.
`default_nettype none
package nbl_pkg;

    localparam int FLEN_W = 16;
    localparam int LINE_W = 32;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    localparam logic [FLEN_W-1:0] MAX_FLEN_RESET = 16'd4096;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_QUOTE   = 3'd1,
        MODE_BRACKET = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_AFTER   = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_FEND  = 2'd1,
        KIND_TEND  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_ESC_AT_END   = 3'd0,
        ERR_OPEN_QUOTE   = 3'd1,
        ERR_OPEN_BRACKET = 3'd2,
        ERR_NO_PERIOD    = 3'd3,
        ERR_JUNK_AFTER   = 3'd4,
        ERR_EARLY_EOL    = 3'd5,
        ERR_UNEXPECTED   = 3'd6,
        ERR_TOO_LONG     = 3'd7
    } err_t;

    typedef struct packed {
        mode_t             mode;
        logic              esc;
        logic [1:0]        fields_done;
        logic              skip;
        logic              at_start;
        logic              content;
        logic              period;
        logic [FLEN_W-1:0] flen;
        logic [LINE_W-1:0] line;
    } parse_state_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [7:0]        tbyte;
        logic [1:0]        field;
        err_t              code;
        logic [LINE_W-1:0] line;
    } lex_result_t;

    localparam parse_state_t STATE_RESET = '{
        mode:        MODE_NORMAL,
        esc:         1'b0,
        fields_done: 2'd0,
        skip:        1'b1,
        at_start:    1'b1,
        content:     1'b0,
        period:      1'b0,
        flen:        '0,
        line:        32'd1
    };

endpackage
`default_nettype wire

>>> rtl/nbl_step.sv
// Per-byte lexer decision: next parse state and at most one result.
`default_nettype none
module nbl_step (
    input  wire nbl_pkg::parse_state_t          st,
    input  wire logic [7:0]                     in_byte,
    input  wire logic                           eos,
    input  wire logic [nbl_pkg::FLEN_W-1:0]     max_len,
    output nbl_pkg::parse_state_t               nxt,
    output nbl_pkg::lex_result_t                res
);

    logic                        is_blank;
    logic                        is_nl;
    logic                        app_ok;
    logic                        app_req;
    logic [nbl_pkg::LINE_W-1:0]  line_inc;
    logic                        skip_eff;
    logic                        done;

    assign is_blank = (in_byte == nbl_pkg::CHAR_SPACE) || (in_byte == nbl_pkg::CHAR_TAB);
    assign is_nl    = (in_byte == nbl_pkg::CHAR_NL);
    assign app_ok   = (st.flen < max_len);
    assign line_inc = (st.line == '1) ? st.line : st.line + 32'd1;

    always_comb
    begin
        nxt       = st;
        res       = '0;
        res.line  = st.line;
        res.field = st.fields_done;
        app_req   = 1'b0;
        skip_eff  = st.skip;
        done      = 1'b0;

        if (eos || (in_byte == 8'd0))
        begin
            if (st.mode != nbl_pkg::MODE_ERROR)
            begin
                if (st.esc)
                begin
                    res.valid = 1'b1;
                    res.kind  = nbl_pkg::KIND_ERROR;
                    res.code  = nbl_pkg::ERR_ESC_AT_END;
                end
                else if (st.mode == nbl_pkg::MODE_AFTER)
                begin
                    res.valid = 1'b1;
                    if (st.period)
                    begin
                        res.kind  = nbl_pkg::KIND_TEND;
                        res.field = 2'd2;
                    end
                    else
                    begin
                        res.kind = nbl_pkg::KIND_ERROR;
                        res.code = nbl_pkg::ERR_NO_PERIOD;
                    end
                end
            end
            nxt = nbl_pkg::STATE_RESET;
        end
        else
        begin
            unique case (st.mode)
                nbl_pkg::MODE_ERROR:
                begin
                end
                nbl_pkg::MODE_COMMENT:
                begin
                    if (is_nl)
                    begin
                        nxt.line = line_inc;
                        nxt.mode = nbl_pkg::MODE_NORMAL;
                    end
                end
                nbl_pkg::MODE_AFTER:
                begin
                    if (is_nl)
                    begin
                        res.valid = 1'b1;
                        if (!st.period)
                        begin
                            res.kind = nbl_pkg::KIND_ERROR;
                            res.code = nbl_pkg::ERR_NO_PERIOD;
                            nxt.mode = nbl_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            res.kind        = nbl_pkg::KIND_TEND;
                            res.field       = 2'd2;
                            nxt.line        = line_inc;
                            nxt.mode        = nbl_pkg::MODE_NORMAL;
                            nxt.fields_done = 2'd0;
                            nxt.at_start    = 1'b1;
                            nxt.content     = 1'b0;
                            nxt.period      = 1'b0;
                            nxt.flen        = '0;
                        end
                    end
                    else if (is_blank)
                    begin
                    end
                    else if ((in_byte == nbl_pkg::CHAR_DOT) && !st.period)
                    begin
                        nxt.period = 1'b1;
                    end
                    else
                    begin
                        res.valid = 1'b1;
                        res.kind  = nbl_pkg::KIND_ERROR;
                        res.code  = nbl_pkg::ERR_JUNK_AFTER;
                        nxt.mode  = nbl_pkg::MODE_ERROR;
                    end
                end
                nbl_pkg::MODE_NORMAL, nbl_pkg::MODE_QUOTE, nbl_pkg::MODE_BRACKET:
                begin
                    if (st.esc)
                    begin
                        nxt.esc = 1'b0;
                        app_req = 1'b1;
                    end
                    else if (in_byte == nbl_pkg::CHAR_BSLASH)
                    begin
                        // backslash marks content but leaves blank skipping alone
                        app_req = 1'b1;
                        if (app_ok)
                        begin
                            nxt.esc     = 1'b1;
                            nxt.content = 1'b1;
                        end
                    end
                    else if (st.mode != nbl_pkg::MODE_NORMAL)
                    begin
                        if (is_nl)
                        begin
                            res.valid = 1'b1;
                            res.kind  = nbl_pkg::KIND_ERROR;
                            res.code  = (st.mode == nbl_pkg::MODE_QUOTE) ?
                                        nbl_pkg::ERR_OPEN_QUOTE : nbl_pkg::ERR_OPEN_BRACKET;
                            nxt.mode  = nbl_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            app_req = 1'b1;
                            if (app_ok &&
                                (((st.mode == nbl_pkg::MODE_QUOTE) &&
                                  (in_byte == nbl_pkg::CHAR_QUOTE)) ||
                                 ((st.mode == nbl_pkg::MODE_BRACKET) &&
                                  (in_byte == nbl_pkg::CHAR_GT))))
                            begin
                                nxt.mode = nbl_pkg::MODE_NORMAL;
                            end
                        end
                    end
                    else
                    begin
                        if (st.skip)
                        begin
                            if (is_blank)
                            begin
                                done = 1'b1;
                            end
                            else if ((in_byte == nbl_pkg::CHAR_HASH) && st.at_start)
                            begin
                                nxt.mode = nbl_pkg::MODE_COMMENT;
                                done     = 1'b1;
                            end
                            else
                            begin
                                nxt.at_start = 1'b0;
                                nxt.skip     = 1'b0;
                                skip_eff     = 1'b0;
                            end
                        end
                        if (!done && !skip_eff)
                        begin
                            if (is_blank ||
                                ((in_byte == nbl_pkg::CHAR_DOT) && (st.fields_done == 2'd2)))
                            begin
                                nxt.skip  = 1'b1;
                                res.valid = 1'b1;
                                res.kind  = nbl_pkg::KIND_FEND;
                                if (st.fields_done < 2'd2)
                                begin
                                    nxt.fields_done = st.fields_done + 2'd1;
                                end
                                else
                                begin
                                    nxt.mode   = nbl_pkg::MODE_AFTER;
                                    nxt.period = (in_byte == nbl_pkg::CHAR_DOT);
                                end
                                nxt.flen = '0;
                            end
                            else if ((in_byte == nbl_pkg::CHAR_QUOTE) ||
                                     (in_byte == nbl_pkg::CHAR_LT))
                            begin
                                app_req = 1'b1;
                                if (app_ok)
                                begin
                                    nxt.mode    = (in_byte == nbl_pkg::CHAR_QUOTE) ?
                                                  nbl_pkg::MODE_QUOTE : nbl_pkg::MODE_BRACKET;
                                    nxt.content = 1'b1;
                                end
                            end
                            else if (is_nl)
                            begin
                                if (st.content)
                                begin
                                    res.valid = 1'b1;
                                    res.kind  = nbl_pkg::KIND_ERROR;
                                    res.code  = nbl_pkg::ERR_EARLY_EOL;
                                    nxt.mode  = nbl_pkg::MODE_ERROR;
                                end
                                else
                                begin
                                    nxt.line     = line_inc;
                                    nxt.skip     = 1'b1;
                                    nxt.at_start = 1'b1;
                                end
                            end
                            else
                            begin
                                res.valid = 1'b1;
                                res.kind  = nbl_pkg::KIND_ERROR;
                                res.code  = nbl_pkg::ERR_UNEXPECTED;
                                nxt.mode  = nbl_pkg::MODE_ERROR;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (app_req)
            begin
                res.valid = 1'b1;
                if (app_ok)
                begin
                    nxt.flen  = st.flen + 16'd1;
                    res.kind  = nbl_pkg::KIND_TOKEN;
                    res.tbyte = in_byte;
                end
                else
                begin
                    res.kind = nbl_pkg::KIND_ERROR;
                    res.code = nbl_pkg::ERR_TOO_LONG;
                    nxt.mode = nbl_pkg::MODE_ERROR;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/nbl_outreg.sv
// Result register on the master side; holds a beat until it is taken.
`default_nettype none
module nbl_outreg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire nbl_pkg::lex_result_t  res,
    output logic                       free,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,  // token_byte, field_index, error_code, line_number
    output logic [1:0]                 m_axis_tuser   // kind
);

    logic                  valid_reg;
    logic                  valid_next;
    nbl_pkg::lex_result_t  data_reg;

    assign free       = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tdata  = {3'b000, data_reg.line, data_reg.code, data_reg.field, data_reg.tbyte};

endmodule
`default_nettype wire

>>> rtl/ntriples_byte_lexer_unit.sv
// Top level of the N-Triples byte lexer: input register, parse state, result register.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] in_byte, tlast end_of_stream
//  m_axis    out  tdata token_byte/field_index/error_code/line_number, tuser kind
//  cfg       in   cfg_we + cfg_wdata: max_field_length
//
// One beat per cycle unless stalled; a byte with a result moves from the input register
// to the result register. The parse state updates as the byte leaves the input register,
// so the per-byte decision logic is the only loop. Reset puts the parser at line 1 between
// fields with max_field_length 4096. A stalled result register holds the input register.
`default_nettype none
module ntriples_byte_lexer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // token_byte, field_index, error_code, line_number
    output logic [1:0]       m_axis_tuser,   // kind
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata       // max_field_length
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          in_eos_reg;
    logic [nbl_pkg::FLEN_W-1:0]    max_len_reg;
    nbl_pkg::parse_state_t         st_reg;
    nbl_pkg::parse_state_t         st_next;
    nbl_pkg::lex_result_t          res;
    logic                          out_free;
    logic                          adv;
    logic                          res_load;
    logic                          s_accept;

    assign adv           = in_valid_reg && out_free;
    assign res_load      = adv && res.valid;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= nbl_pkg::MAX_FLEN_RESET;
            st_reg       <= nbl_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (adv)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    nbl_step u_step (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .eos     (in_eos_reg),
        .max_len (max_len_reg),
        .nxt     (st_next),
        .res     (res)
    );

    nbl_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // once in error, ordinary bytes keep it there silently
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (st_reg.mode == nbl_pkg::MODE_ERROR) && !in_eos_reg && (in_byte_reg != 8'd0))
        |=> ((st_reg.mode == nbl_pkg::MODE_ERROR) && !res_load))
        else $error("lexer left error mode or produced a beat");

    // an error beat from an ordinary byte parks the parser in error mode
    a_err_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res.kind == nbl_pkg::KIND_ERROR) && !in_eos_reg && (in_byte_reg != 8'd0))
        |=> (st_reg.mode == nbl_pkg::MODE_ERROR))
        else $error("error beat without error mode");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.fields_done != 2'd3) && (st_reg.line != '0))
        else $error("field count or line counter out of range");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the N-Triples byte lexer: directed table, then random text streams.
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        nbl_pkg::kind_t             kind;
        logic [7:0]                 tbyte;
        logic [1:0]                 field;
        nbl_pkg::err_t              code;
        logic [nbl_pkg::LINE_W-1:0] line;
    } lex_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;   // beat below is the expected result, not the predictor's
        logic       has;
        lex_beat_t  beat;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
    } text_beat_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    ntriples_byte_lexer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // lexer state as the predictor tracks it
    logic [nbl_pkg::FLEN_W-1:0] max_flen;
    nbl_pkg::mode_t             lex_mode;
    logic                       lex_esc;
    logic [1:0]                 lex_fields;
    logic                       lex_skip;
    logic                       lex_at_start;
    logic                       lex_content;
    logic                       lex_period;
    logic [nbl_pkg::FLEN_W-1:0] lex_flen;
    logic [nbl_pkg::LINE_W-1:0] lex_line;

    lex_beat_t  pending_beats[$];
    text_beat_t plan_q[$];
    dir_row_t   dir_rows [DIR_ROWS];

    int fail_cnt  = 0;
    int sent_cnt  = 0;
    int cycle_cnt = 0;
    int send_idle = 0;
    int stall_pct = 0;
    int hold_ask  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic void lex_clear();
        lex_mode     = nbl_pkg::MODE_NORMAL;
        lex_esc      = 1'b0;
        lex_fields   = 2'd0;
        lex_skip     = 1'b1;
        lex_at_start = 1'b1;
        lex_content  = 1'b0;
        lex_period   = 1'b0;
        lex_flen     = '0;
        lex_line     = 32'd1;
    endfunction

    function automatic void bump_line();
        if (lex_line != '1)
            lex_line = lex_line + 1'b1;
    endfunction

    function automatic lex_beat_t lex_beat(nbl_pkg::kind_t k, logic [7:0] tb, logic [1:0] f,
                                           nbl_pkg::err_t c);
        lex_beat_t r;
        r.kind  = k;
        r.tbyte = tb;
        r.field = (f > 2'd2) ? 2'd2 : f;
        r.code  = c;
        r.line  = lex_line;
        return r;
    endfunction

    function automatic bit lex_fail(nbl_pkg::err_t c, output lex_beat_t r);
        r = lex_beat(nbl_pkg::KIND_ERROR, 8'h00, lex_fields, c);
        lex_mode = nbl_pkg::MODE_ERROR;
        return 1'b1;
    endfunction

    function automatic bit lex_append(logic [7:0] b, output lex_beat_t r);
        if (lex_flen >= max_flen)
            return lex_fail(nbl_pkg::ERR_TOO_LONG, r);
        lex_flen = lex_flen + 1'b1;
        r = lex_beat(nbl_pkg::KIND_TOKEN, b, lex_fields, nbl_pkg::ERR_ESC_AT_END);
        return 1'b1;
    endfunction

    // Expected result of one accepted byte; returns 0 when the byte yields nothing.
    function automatic bit lex_step(logic [7:0] b, logic eos, output lex_beat_t r);
        bit got;
        bit quote;
        got = 1'b0;
        r = '0;
        if (eos || b == 8'h00)
        begin
            if (lex_mode != nbl_pkg::MODE_ERROR)
            begin
                if (lex_esc)
                    got = lex_fail(nbl_pkg::ERR_ESC_AT_END, r);
                else if (lex_mode == nbl_pkg::MODE_AFTER)
                begin
                    if (lex_period)
                    begin
                        r = lex_beat(nbl_pkg::KIND_TEND, 8'h00, 2'd2, nbl_pkg::ERR_ESC_AT_END);
                        got = 1'b1;
                    end
                    else
                        got = lex_fail(nbl_pkg::ERR_NO_PERIOD, r);
                end
            end
            lex_clear();
            return got;
        end

        case (lex_mode)
            nbl_pkg::MODE_ERROR:
                return 1'b0;
            nbl_pkg::MODE_COMMENT:
            begin
                if (b == nbl_pkg::CHAR_NL)
                begin
                    bump_line();
                    lex_mode = nbl_pkg::MODE_NORMAL;
                end
                return 1'b0;
            end
            nbl_pkg::MODE_AFTER:
            begin
                if (b == nbl_pkg::CHAR_NL)
                begin
                    if (!lex_period)
                        return lex_fail(nbl_pkg::ERR_NO_PERIOD, r);
                    r = lex_beat(nbl_pkg::KIND_TEND, 8'h00, 2'd2, nbl_pkg::ERR_ESC_AT_END);
                    bump_line();
                    lex_mode     = nbl_pkg::MODE_NORMAL;
                    lex_fields   = 2'd0;
                    lex_at_start = 1'b1;
                    lex_content  = 1'b0;
                    lex_period   = 1'b0;
                    lex_flen     = '0;
                    return 1'b1;
                end
                if (b == nbl_pkg::CHAR_SPACE || b == nbl_pkg::CHAR_TAB)
                    return 1'b0;
                if (b == nbl_pkg::CHAR_DOT && !lex_period)
                begin
                    lex_period = 1'b1;
                    return 1'b0;
                end
                return lex_fail(nbl_pkg::ERR_JUNK_AFTER, r);
            end
            default: ;
        endcase

        if (lex_esc)
        begin
            lex_esc = 1'b0;
            return lex_append(b, r);
        end
        if (b == nbl_pkg::CHAR_BSLASH)
        begin
            got = lex_append(b, r);
            if (lex_mode != nbl_pkg::MODE_ERROR)
            begin
                lex_esc = 1'b1;
                lex_content = 1'b1;
            end
            return got;
        end

        if (lex_mode == nbl_pkg::MODE_QUOTE || lex_mode == nbl_pkg::MODE_BRACKET)
        begin
            quote = (lex_mode == nbl_pkg::MODE_QUOTE);
            if (b == nbl_pkg::CHAR_NL)
                return lex_fail(quote ? nbl_pkg::ERR_OPEN_QUOTE : nbl_pkg::ERR_OPEN_BRACKET, r);
            got = lex_append(b, r);
            if (lex_mode != nbl_pkg::MODE_ERROR &&
                b == (quote ? nbl_pkg::CHAR_QUOTE : nbl_pkg::CHAR_GT))
                lex_mode = nbl_pkg::MODE_NORMAL;
            return got;
        end

        if (lex_skip)
        begin
            if (b == nbl_pkg::CHAR_SPACE || b == nbl_pkg::CHAR_TAB)
                return 1'b0;
            if (b == nbl_pkg::CHAR_HASH && lex_at_start)
            begin
                lex_mode = nbl_pkg::MODE_COMMENT;
                return 1'b0;
            end
            lex_at_start = 1'b0;
            lex_skip = 1'b0;
        end

        // separator, or a period closing the object field
        if (b == nbl_pkg::CHAR_SPACE || b == nbl_pkg::CHAR_TAB ||
            (b == nbl_pkg::CHAR_DOT && lex_fields == 2'd2))
        begin
            lex_skip = 1'b1;
            r = lex_beat(nbl_pkg::KIND_FEND, 8'h00, lex_fields, nbl_pkg::ERR_ESC_AT_END);
            if (lex_fields < 2'd2)
                lex_fields = lex_fields + 1'b1;
            else
            begin
                lex_mode = nbl_pkg::MODE_AFTER;
                lex_period = (b == nbl_pkg::CHAR_DOT);
            end
            lex_flen = '0;
            return 1'b1;
        end

        if (b == nbl_pkg::CHAR_QUOTE || b == nbl_pkg::CHAR_LT)
        begin
            got = lex_append(b, r);
            if (lex_mode != nbl_pkg::MODE_ERROR)
            begin
                lex_mode = (b == nbl_pkg::CHAR_QUOTE) ? nbl_pkg::MODE_QUOTE
                                                       : nbl_pkg::MODE_BRACKET;
                lex_content = 1'b1;
            end
            return got;
        end

        if (b == nbl_pkg::CHAR_NL)
        begin
            if (lex_content)
                return lex_fail(nbl_pkg::ERR_EARLY_EOL, r);
            bump_line();
            lex_skip = 1'b1;
            lex_at_start = 1'b1;
            return 1'b0;
        end

        return lex_fail(nbl_pkg::ERR_UNEXPECTED, r);
    endfunction

    function automatic dir_row_t pred_row(logic [7:0] b, logic eos);
        return '{b: b, eos: eos, typed: 1'b0, has: 1'b0, beat: '0};
    endfunction

    function automatic dir_row_t quiet_row(logic [7:0] b, logic eos);
        return '{b: b, eos: eos, typed: 1'b1, has: 1'b0, beat: '0};
    endfunction

    function automatic dir_row_t typed_row(logic [7:0] b, logic eos, nbl_pkg::kind_t k,
                                           logic [7:0] tb, logic [1:0] f, nbl_pkg::err_t c,
                                           logic [nbl_pkg::LINE_W-1:0] ln);
        return '{b: b, eos: eos, typed: 1'b1, has: 1'b1,
                 beat: '{kind: k, tbyte: tb, field: f, code: c, line: ln}};
    endfunction

    // ---------------- checking ----------------
    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 'h%0h actual 'h%0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        lex_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual tuser %0d tdata 'h%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("token_byte", want.tbyte, m_axis_tdata[7:0]);
                check_field("field_index", want.field, m_axis_tdata[9:8]);
                check_field("error_code", want.code, m_axis_tdata[12:10]);
                check_field("line_number", want.line, m_axis_tdata[44:13]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever hold_ask moves
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(input logic [7:0] b, input logic eos,
                             output bit got, output lex_beat_t r);
        if (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_cnt++;
        got = lex_step(b, eos, r);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_flen(logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        max_flen = v;
    endtask

    function automatic void add(logic [7:0] b);
        plan_q.push_back('{b: b, eos: 1'b0});
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(1) ? nbl_pkg::CHAR_SPACE : nbl_pkg::CHAR_TAB;
    endfunction

    function automatic void add_sep();
        add(blank());
        if ($urandom_range(3) == 0)
            add(blank());
    endfunction

    function automatic void add_field();
        bit quote;
        int n;
        logic [7:0] c;
        quote = $urandom_range(1);
        add(quote ? nbl_pkg::CHAR_QUOTE : nbl_pkg::CHAR_LT);
        n = ($urandom_range(7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        repeat (n)
        begin
            if ($urandom_range(7) == 0)
            begin
                add(nbl_pkg::CHAR_BSLASH);
                add(any_byte());
            end
            else
            begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == nbl_pkg::CHAR_BSLASH ||
                    c == (quote ? nbl_pkg::CHAR_QUOTE : nbl_pkg::CHAR_GT))
                    c = 8'h61;
                add(c);
            end
        end
        add(quote ? nbl_pkg::CHAR_QUOTE : nbl_pkg::CHAR_GT);
    endfunction

    function automatic void add_line();
        int sel;
        int start;
        int k;
        logic [7:0] c;
        start = plan_q.size();
        sel = $urandom_range(99);
        if ($urandom_range(3) == 0)
            add(blank());
        if (sel < 10)
        begin
            add(nbl_pkg::CHAR_HASH);
            repeat ($urandom_range(0, 6))
            begin
                c = any_byte();
                add(c == nbl_pkg::CHAR_NL ? 8'h7E : c);
            end
        end
        else if (sel < 18)
        begin
            repeat ($urandom_range(0, 3)) add(blank());
        end
        else
        begin
            add_field();
            add_sep();
            add_field();
            add_sep();
            if ($urandom_range(5) == 0)
                add(nbl_pkg::CHAR_DOT);         // empty object
            else
            begin
                add_field();
                case ($urandom_range(5))
                    0: add(nbl_pkg::CHAR_DOT);
                    1:
                    begin
                        add_sep();
                        add(nbl_pkg::CHAR_DOT);
                    end
                    2:
                    begin
                        add_sep();
                        add(nbl_pkg::CHAR_DOT);
                        add(blank());
                    end
                    3: add_sep();               // no period
                    4:
                    begin
                        add(nbl_pkg::CHAR_DOT);
                        add(nbl_pkg::CHAR_DOT);
                    end
                    default:
                    begin
                        add(nbl_pkg::CHAR_DOT);
                        add(blank());
                    end
                endcase
            end
            if (sel >= 88)
            begin
                k = $urandom_range(start, plan_q.size() - 1);
                plan_q[k].b = any_byte();
            end
        end
        add(nbl_pkg::CHAR_NL);
    endfunction

    // a few lines, sometimes cut short, then end of stream by tlast or a zero byte
    function automatic void gen_stream();
        int line_start;
        int cut;
        repeat ($urandom_range(1, 4))
        begin
            line_start = plan_q.size();
            add_line();
        end
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(line_start, plan_q.size() - 1);
            while (plan_q.size() > cut)
                void'(plan_q.pop_back());
        end
        if ($urandom_range(1))
            plan_q.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b1});
        else
            plan_q.push_back('{b: 8'h00, eos: 1'b0});
    endfunction

    task automatic run_phase(logic [15:0] flen, int idle, int stall, int n_items, bit hold);
        int goal;
        bit held;
        bit got;
        lex_beat_t r;
        text_beat_t t;
        settle();
        write_max_flen(flen);
        send_idle = idle;
        stall_pct <= stall;
        goal = sent_cnt + n_items;
        held = 1'b0;
        while (sent_cnt < goal)
        begin
            gen_stream();
            while (plan_q.size() != 0)
            begin
                t = plan_q.pop_front();
                send_byte(t.b, t.eos, got, r);
                if (got)
                    pending_beats.push_back(r);
                if (hold && !held && sent_cnt >= goal - n_items + 20)
                begin
                    hold_ask <= hold_ask + 1;
                    held = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        bit got;
        lex_beat_t r;
        max_flen = nbl_pkg::MAX_FLEN_RESET;
        lex_clear();
        dir_rows = '{
            typed_row(nbl_pkg::CHAR_LT, 1'b0, nbl_pkg::KIND_TOKEN, nbl_pkg::CHAR_LT, 2'd0,
                      nbl_pkg::ERR_ESC_AT_END, 32'd1),
            pred_row(nbl_pkg::CHAR_GT, 1'b0),
            pred_row(nbl_pkg::CHAR_SPACE, 1'b0),
            pred_row(nbl_pkg::CHAR_QUOTE, 1'b0),
            pred_row(nbl_pkg::CHAR_BSLASH, 1'b0),
            pred_row(nbl_pkg::CHAR_NL, 1'b0),   // escaped newline stays in the field
            pred_row(nbl_pkg::CHAR_QUOTE, 1'b0),
            pred_row(nbl_pkg::CHAR_TAB, 1'b0),
            pred_row(nbl_pkg::CHAR_DOT, 1'b0),  // empty object
            typed_row(nbl_pkg::CHAR_NL, 1'b0, nbl_pkg::KIND_TEND, 8'h00, 2'd2,
                      nbl_pkg::ERR_ESC_AT_END, 32'd1),
            quiet_row(nbl_pkg::CHAR_HASH, 1'b0), // comment line
            quiet_row(8'hFF, 1'b0),
            quiet_row(nbl_pkg::CHAR_NL, 1'b0),
            quiet_row(nbl_pkg::CHAR_NL, 1'b0),  // blank line
            pred_row(nbl_pkg::CHAR_LT, 1'b0),
            pred_row(nbl_pkg::CHAR_GT, 1'b0),
            typed_row(nbl_pkg::CHAR_NL, 1'b0, nbl_pkg::KIND_ERROR, 8'h00, 2'd0,
                      nbl_pkg::ERR_EARLY_EOL, 32'd4),
            quiet_row(8'h78, 1'b0),             // silent after an error
            quiet_row(8'h00, 1'b0),
            typed_row(nbl_pkg::CHAR_BSLASH, 1'b0, nbl_pkg::KIND_TOKEN, nbl_pkg::CHAR_BSLASH,
                      2'd0, nbl_pkg::ERR_ESC_AT_END, 32'd1),
            typed_row(8'hA5, 1'b1, nbl_pkg::KIND_ERROR, 8'h00, 2'd0,
                      nbl_pkg::ERR_ESC_AT_END, 32'd1),
            pred_row(nbl_pkg::CHAR_QUOTE, 1'b0),
            typed_row(nbl_pkg::CHAR_NL, 1'b0, nbl_pkg::KIND_ERROR, 8'h00, 2'd0,
                      nbl_pkg::ERR_OPEN_QUOTE, 32'd1),
            quiet_row(8'h00, 1'b0),
            typed_row(8'h71, 1'b0, nbl_pkg::KIND_ERROR, 8'h00, 2'd0,
                      nbl_pkg::ERR_UNEXPECTED, 32'd1),
            quiet_row(8'h00, 1'b1)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b, dir_rows[i].eos, got, r);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].has)
                    pending_beats.push_back(dir_rows[i].beat);
            end
            else if (got)
                pending_beats.push_back(r);
        end

        run_phase(16'd65535, 0, 0, 95, 1'b1);
        run_phase(16'd1, 65, 0, 50, 1'b0);
        run_phase(16'd3, 0, 65, 75, 1'b0);
        run_phase(16'd9, 34, 34, 95, 1'b0);
        run_phase(nbl_pkg::MAX_FLEN_RESET, 0, 0, 85, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && pending_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/nbl_pkg.sv
rtl/nbl_step.sv
rtl/nbl_outreg.sv
rtl/ntriples_byte_lexer_unit.sv
tb/sv/tb_top.sv
